FILE: sv/assert_macros.svh
// assertion macros shared by the transcoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/u8u16_pkg.sv
// types and constants for the utf-8 to utf-16 transcoder
package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [21:0] CP_MAX       = 22'h10FFFF;
    localparam logic [21:0] CP_SUPP_BASE = 22'h010000;
    localparam logic [15:0] SURR_LO_MIN  = 16'hD800;
    localparam logic [15:0] SURR_LO_MAX  = 16'hDFFF;
    localparam logic [15:0] HIGH_BASE    = 16'hD800;
    localparam logic [15:0] LOW_BASE     = 16'hDC00;
    localparam logic [15:0] MIN_3BYTE    = 16'h0800;
    localparam logic [15:0] MIN_2BYTE    = 16'h0080;
    localparam int          MAX_UNITS    = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
    } unit_t;

    // all units that one accepted byte gives, in output order
    typedef struct packed {
        logic [2:0]  count;
        unit_t [3:0] units;
    } unit_job_t;

    // handshake between queue and back end
    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctrl_t;

endpackage

FILE: sv/utf8_to_utf16_transcoder_top.sv
// top level of the utf-8 to utf-16 transcoder
// Takes one UTF-8 byte per transfer and gives UTF-16 code units, surrogate pairs
// for code points of 0x10000 and up, and U+FFFD for each byte of a bad, overlong,
// surrogate, too-large or cut-off sequence. Each byte gives zero to four units;
// the last one carries last_of_run. A byte is taken every cycle while the unit
// queue (QUEUE_DEPTH lists) has room; the output side delivers one unit per
// cycle while out_ready is high, so a byte that gives several units holds the
// back end until all are out, and the queue absorbs the difference. When
// nothing stalls, a byte's first unit passes a queue entry, then the output
// register, before it is offered. No clearing pass is needed after reset.
module utf8_to_utf16_transcoder_top
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      q_space, push, head_valid;
    unit_job_t job, head_job;
    q_ctrl_t   ctrl;

    u8u16_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_space  (q_space),
        .push     (push),
        .job      (job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (job),
        .space      (q_space),
        .ctrl_in    (ctrl),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u8u16_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .ctrl       (ctrl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

FILE: sv/u8u16_front.sv
// front end: accepts bytes, tracks the open sequence, builds the unit list per byte
`include "assert_macros.svh"
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    input  logic      q_space,
    output logic      push,
    output unit_job_t job
);

    logic [2:0] held_reg, held_next;
    logic [2:0] need_reg, need_next;
    logic [7:0] held_bytes_reg [0:2];

    logic       accept;
    logic [7:0] b;
    logic       open_seq, is_cont, finish, start_here;
    logic       st_ascii, st_lead;
    logic [2:0] held_inc, lead_need, held_after;
    logic [21:0] cp, v;
    logic       cp_ok;
    logic [2:0] rep_a, rep_b;
    logic [1:0] mid_n;
    unit_t      mid_unit [0:1];
    logic       hb_we;
    logic [1:0] hb_idx;

    assign accept   = in_valid && in_ready;
    assign in_ready = q_space;
    assign b        = in_item.in_byte;
    assign push     = accept && (job.count != 3'd0);

    // classify the byte against the open sequence
    assign open_seq   = (held_reg != 3'd0);
    assign is_cont    = (b[7:6] == 2'b10);
    assign held_inc   = held_reg + 3'd1;
    assign finish     = open_seq && is_cont && (held_inc >= need_reg);
    assign start_here = !open_seq || !is_cont;
    assign st_ascii   = !b[7];
    assign st_lead    = (b[7:6] == 2'b11);
    assign lead_need  = !b[5] ? 3'd2 : (!b[4] ? 3'd3 : 3'd4);

    // code point assembly and range checks for a completed sequence
    always_comb
    begin
        cp    = '0;
        cp_ok = 1'b0;
        case (need_reg)
            3'd2:
            begin
                cp    = {11'd0, held_bytes_reg[0][4:0], b[5:0]};
                cp_ok = (cp >= {6'd0, MIN_2BYTE});
            end
            3'd3:
            begin
                cp    = {6'd0, held_bytes_reg[0][3:0], held_bytes_reg[1][5:0], b[5:0]};
                cp_ok = (cp >= {6'd0, MIN_3BYTE}) &&
                        !((cp >= {6'd0, SURR_LO_MIN}) && (cp <= {6'd0, SURR_LO_MAX}));
            end
            3'd4:
            begin
                cp    = {held_bytes_reg[0][3:0], held_bytes_reg[1][5:0],
                         held_bytes_reg[2][5:0], b[5:0]};
                cp_ok = (cp >= CP_SUPP_BASE) && (cp <= CP_MAX);
            end
            default:
            begin
                cp    = '0;
                cp_ok = 1'b0;
            end
        endcase
    end

    assign v = cp - CP_SUPP_BASE;

    // unit list: leading replacements, decoded units, trailing flush
    always_comb
    begin
        rep_a       = 3'd0;
        mid_n       = 2'd0;
        mid_unit[0] = '{code_unit: REPL_CHAR, is_replacement: 1'b1};
        mid_unit[1] = '{code_unit: REPL_CHAR, is_replacement: 1'b1};
        held_after  = 3'd0;
        need_next   = 3'd0;
        hb_we       = 1'b0;
        hb_idx      = 2'd0;
        if (open_seq && !is_cont)
        begin
            rep_a = held_reg;
        end
        if (start_here)
        begin
            if (st_ascii)
            begin
                mid_n       = 2'd1;
                mid_unit[0] = '{code_unit: {8'd0, b}, is_replacement: 1'b0};
            end
            else if (st_lead)
            begin
                held_after = 3'd1;
                need_next  = lead_need;
                hb_we      = 1'b1;
                hb_idx     = 2'd0;
            end
            else
            begin
                mid_n = 2'd1;
            end
        end
        else if (finish)
        begin
            if (!cp_ok)
            begin
                rep_a = need_reg;
            end
            else if (cp >= CP_SUPP_BASE)
            begin
                mid_n       = 2'd2;
                mid_unit[0] = '{code_unit: HIGH_BASE + {6'd0, v[19:10]},
                                is_replacement: 1'b0};
                mid_unit[1] = '{code_unit: LOW_BASE + {6'd0, v[9:0]},
                                is_replacement: 1'b0};
            end
            else
            begin
                mid_n       = 2'd1;
                mid_unit[0] = '{code_unit: cp[15:0], is_replacement: 1'b0};
            end
        end
        else
        begin
            held_after = held_inc;
            need_next  = need_reg;
            hb_we      = 1'b1;
            hb_idx     = held_reg[1:0];
        end
        rep_b = in_item.end_of_data ? held_after : 3'd0;
        if (in_item.end_of_data)
        begin
            held_next = 3'd0;
            need_next = 3'd0;
        end
        else
        begin
            held_next = held_after;
        end
    end

    // pack the list into slots
    always_comb
    begin
        logic [2:0] pos;
        logic [2:0] rel;
        job.count = rep_a + {1'b0, mid_n} + rep_b;
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            pos = 3'(i);
            rel = pos - rep_a;
            if ((pos >= rep_a) && (pos < (rep_a + {1'b0, mid_n})))
            begin
                job.units[i] = mid_unit[rel[0]];
            end
            else
            begin
                job.units[i] = '{code_unit: REPL_CHAR, is_replacement: 1'b1};
            end
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 3'd0;
            need_reg <= 3'd0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            need_reg <= need_next;
        end
    end

    // held byte storage
    always_ff @(posedge clk)
    begin
        if (accept && hb_we)
        begin
            held_bytes_reg[hb_idx] <= b;
        end
    end

    `ASSERT_IMPLIES(a_held_below_need, clk, rst_n, held_reg != 3'd0, held_reg < need_reg, "held count not below needed count")
    `ASSERT_IMPLIES(a_push_count, clk, rst_n, push, job.count <= 3'(MAX_UNITS), "unit list too long")

endmodule

FILE: sv/u8u16_queue.sv
// short queue of unit lists between front and back end
`include "assert_macros.svh"
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  unit_job_t push_job,
    output logic      space,
    input  q_ctrl_t   ctrl_in,
    output logic      head_valid,
    output unit_job_t head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    unit_job_t        mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop        = ctrl_in.valid && ctrl_in.pop;
    assign space      = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count past depth")
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")

endmodule

FILE: sv/u8u16_back.sv
// back end: walks the head unit list and feeds the output register
`include "assert_macros.svh"
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  unit_job_t head_job,
    output q_ctrl_t   ctrl,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;
    logic       load, last;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign last      = (({1'b0, idx_reg} + 3'd1) == head_job.count);
    assign ctrl      = '{valid: head_valid, pop: load && last};
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // next unit index and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg.code_unit      <= head_job.units[idx_reg].code_unit;
            out_item_reg.is_replacement <= head_job.units[idx_reg].is_replacement;
            out_item_reg.last_of_run    <= last;
        end
    end

    `ASSERT_IMPLIES(a_idx_in_list, clk, rst_n, head_valid, {1'b0, idx_reg} < head_job.count, "unit index past list length")

endmodule

FILE: tb/tb_utf8_to_utf16_transcoder_top.sv
// self-checking testbench for the utf-8 to utf-16 transcoder top level
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_top;
    import u8u16_pkg::*;

    // directed row: byte, end flag, and a typed-in single unit where obvious
    typedef struct packed {
        logic [7:0]  b;
        logic        eod;
        logic        typed;
        logic [15:0] unit;
        logic        repl;
    } dir_row_t;

    localparam int DIR_ROWS_N = 25;
    localparam int RANDOM_BYTES = 480;
    localparam int BACKLOG_AT = 300;
    localparam int BACKLOG_CYCLES = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS = 100;

    // extremes, stray and bad continuations, overlong, valid 3- and 4-byte, surrogate, too large, cut off
    localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
        '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{8'h7F, 1'b0, 1'b1, 16'h007F, 1'b0},
        '{8'h80, 1'b0, 1'b1, REPL_CHAR, 1'b1},
        '{8'hBF, 1'b0, 1'b1, REPL_CHAR, 1'b1},
        '{8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hEF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hBD, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hED, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h98, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h82, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'hF0, 1'b1, 1'b1, REPL_CHAR, 1'b1}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // typed-in expectation that travels with the byte on the bus
    logic        row_typed;
    logic [15:0] row_unit;
    logic        row_repl;

    // decoder state of the predictor
    logic [7:0] seq_bytes [4];
    int         seq_have;
    int         seq_len;

    // units produced by the byte being decoded
    out_item_t  run_units [4];
    int         run_len;

    out_item_t  pending_units [$];

    int errors;
    int bytes_in;
    int eod_in;
    int in_stalls;
    int units_out;
    int repl_out;
    int halves_out;
    int tx_index;
    bit backlog_done;

    utf8_to_utf16_transcoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset held low, then released on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic add_unit(input logic [15:0] u, input logic r);
        if (run_len < MAX_UNITS)
        begin
            run_units[run_len] = '{code_unit: u, is_replacement: r, last_of_run: 1'b0};
            run_len++;
        end
    endtask

    // every held byte of a failed sequence becomes a replacement
    task automatic flush_seq();
        for (int i = 0; i < seq_have; i++)
            add_unit(REPL_CHAR, 1'b1);
        seq_have = 0;
        seq_len = 0;
    endtask

    task automatic open_seq(input logic [7:0] b);
        if (b < 8'h80)
            add_unit({8'h00, b}, 1'b0);
        else if (b < 8'hC0)
            add_unit(REPL_CHAR, 1'b1);
        else
        begin
            seq_bytes[0] = b;
            seq_have = 1;
            seq_len = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : 4;
        end
    endtask

    // full sequence collected: range checks, then one unit or a surrogate pair
    task automatic close_seq();
        logic [21:0] cp;
        logic [19:0] off;
        logic        ok;
        case (seq_len)
            2:
            begin
                cp = {11'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
                ok = cp >= {6'd0, MIN_2BYTE};
            end
            3:
            begin
                cp = {6'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
                ok = (cp >= {6'd0, MIN_3BYTE}) &&
                     !(cp >= {6'd0, SURR_LO_MIN} && cp <= {6'd0, SURR_LO_MAX});
            end
            default:
            begin
                cp = {seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                      seq_bytes[3][5:0]};
                ok = (cp >= CP_SUPP_BASE) && (cp <= CP_MAX);
            end
        endcase
        if (!ok)
            flush_seq();
        else
        begin
            if (cp >= CP_SUPP_BASE)
            begin
                off = 20'(cp - CP_SUPP_BASE);
                add_unit(HIGH_BASE + {6'd0, off[19:10]}, 1'b0);
                add_unit(LOW_BASE + {6'd0, off[9:0]}, 1'b0);
            end
            else
                add_unit(cp[15:0], 1'b0);
            seq_have = 0;
            seq_len = 0;
        end
    endtask

    // predicted units for one accepted byte, left in run_units
    task automatic decode_byte(input in_item_t it);
        run_len = 0;
        if (seq_have == 0)
            open_seq(it.in_byte);
        else if (it.in_byte[7:6] == 2'b10)
        begin
            seq_bytes[seq_have] = it.in_byte;
            seq_have++;
            if (seq_have >= seq_len)
                close_seq();
        end
        else
        begin
            flush_seq();
            open_seq(it.in_byte);
        end
        if (it.end_of_data && seq_have > 0)
            flush_seq();
        if (run_len > 0)
            run_units[run_len-1].last_of_run = 1'b1;
    endtask

    // mostly no gap, some short ones, a few long ones, none in calm stretches
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic pick_eod(input bit at_end);
        return $urandom_range(0, 99) < (at_end ? 8 : 3);
    endfunction

    function automatic logic [20:0] pick_cp(input int len);
        case (len)
            1: return 21'($urandom_range(0, 'h7F));
            2: return 21'($urandom_range('h80, 'h7FF));
            3: return 21'($urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h10FFFF));
        endcase
    endfunction

    // one input transfer, entered and left on a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eod, input logic typed,
                             input logic [15:0] u, input logic r);
        int gap;
        gap = pick_gap(((tx_index / 40) % 4) == 0);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item = '{in_byte: b, end_of_data: eod};
        row_typed = typed;
        row_unit = u;
        row_repl = r;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tx_index++;
        @(negedge clk);
    endtask

    // encode cp in len bytes (overlong forms allowed) and send the first keep of them
    task automatic send_cp(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] b [4];
        case (len)
            1: b[0] = {1'b0, cp[6:0]};
            2:
            begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            send_byte(b[i], pick_eod(i == keep - 1), 1'b0, 16'h0000, 1'b0);
    endtask

    // predict on input transfers, check on output transfers
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                in_stalls++;
            if (in_valid && in_ready)
            begin
                bytes_in++;
                if (in_item.end_of_data)
                    eod_in++;
                decode_byte(in_item);
                if (row_typed)
                begin
                    want = '{code_unit: row_unit, is_replacement: row_repl, last_of_run: 1'b1};
                    pending_units.push_back(want);
                end
                else
                    for (int i = 0; i < run_len; i++)
                        pending_units.push_back(run_units[i]);
            end
            if (out_valid && out_ready)
            begin
                units_out++;
                if (out_item.is_replacement)
                    repl_out++;
                else if (out_item.code_unit >= SURR_LO_MIN && out_item.code_unit <= SURR_LO_MAX)
                    halves_out++;
                if (pending_units.size() == 0)
                    report_mismatch($sformatf("unit %h arrived with nothing expected",
                                              out_item.code_unit));
                else
                begin
                    want = pending_units.pop_front();
                    if (out_item.code_unit !== want.code_unit)
                        report_mismatch($sformatf("code_unit %h, expected %h",
                                                  out_item.code_unit, want.code_unit));
                    if (out_item.is_replacement !== want.is_replacement)
                        report_mismatch($sformatf("is_replacement %b on unit %h, expected %b",
                                                  out_item.is_replacement, want.code_unit,
                                                  want.is_replacement));
                    if (out_item.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b on unit %h, expected %b",
                                                  out_item.last_of_run, want.code_unit,
                                                  want.last_of_run));
                end
            end
        end
    end

    // output side: random stalls, calm stretches, one long backlog hold
    initial
    begin : rx_side
        int stall_left;
        int cyc;
        out_ready = 1'b0;
        stall_left = 0;
        cyc = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!backlog_done && bytes_in >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                stall_left = BACKLOG_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                stall_left = pick_gap(((cyc / 150) % 3) == 0);
            end
        end
    end

    // input side: directed table, then random byte stream, then drain and verdict
    initial
    begin : tx_side
        int          kind;
        int          len;
        logic [20:0] cp;
        in_valid = 1'b0;
        in_item = '0;
        row_typed = 1'b0;
        row_unit = '0;
        row_repl = 1'b0;
        seq_have = 0;
        seq_len = 0;
        errors = 0;
        bytes_in = 0;
        eod_in = 0;
        in_stalls = 0;
        units_out = 0;
        repl_out = 0;
        halves_out = 0;
        tx_index = 0;
        backlog_done = 1'b0;
        wait (rst_n);
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS_N; i++)
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].eod, DIR_ROWS[i].typed,
                      DIR_ROWS[i].unit, DIR_ROWS[i].repl);

        // mostly well-formed characters, some noise and broken sequences
        while (tx_index < DIR_ROWS_N + RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 28)
                send_cp(pick_cp(1), 1, 1);
            else if (kind < 70)
            begin
                len = (kind < 42) ? 2 : (kind < 56) ? 3 : 4;
                send_cp(pick_cp(len), len, len);
            end
            else if (kind < 78)
                send_byte(8'($urandom_range(0, 255)), pick_eod(1'b1), 1'b0, 16'h0000, 1'b0);
            else if (kind < 86)
            begin
                // cut-off sequence, broken by whatever follows
                len = $urandom_range(2, 4);
                send_cp(pick_cp(len), len, $urandom_range(1, len - 1));
            end
            else if (kind < 92)
            begin
                // overlong form
                len = $urandom_range(2, 4);
                cp = pick_cp(len - 1);
                send_cp(cp, len, len);
            end
            else if (kind < 95)
                send_cp(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
            else if ($urandom_range(0, 1) == 0)
                send_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
            else
            begin
                // lead that can never be valid, with three continuations
                send_byte(8'($urandom_range('hF8, 'hFF)), 1'b0, 1'b0, 16'h0000, 1'b0);
                for (int i = 0; i < 3; i++)
                    send_byte(8'($urandom_range('h80, 'hBF)), pick_eod(i == 2), 1'b0,
                              16'h0000, 1'b0);
            end
        end
        in_valid = 1'b0;

        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_units.size() != 0)
            report_mismatch($sformatf("%0d units never arrived", pending_units.size()));

        $display("covered %0d bytes (%0d with end of data), %0d cycles of input backpressure",
                 bytes_in, eod_in, in_stalls);
        $display("checked %0d units: %0d replacements, %0d surrogate halves, %0d mismatches",
                 units_out, repl_out, halves_out, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_front.sv
sv/u8u16_queue.sv
sv/u8u16_back.sv
sv/utf8_to_utf16_transcoder_top.sv
tb/tb_utf8_to_utf16_transcoder_top.sv
